// ----- rtl/core/brtc_pkg.sv -----
// shared types, constants and bcd helpers for the bus rtc register file
`default_nettype none

package brtc_pkg;

  localparam int STORE_BYTES = 64;
  localparam int PTR_W       = $clog2(STORE_BYTES);
  localparam int TIME_BYTES  = 7;
  localparam int FIX_BYTES   = 8;
  localparam int WIDE_W      = 9;

  localparam logic [6:0]  DEV_ADDR_RESET = 7'd104;
  localparam logic [15:0] TPS_RESET      = 16'd1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TPS      = 1'd1;

  typedef enum logic [2:0] {
    ACT_TICK,
    ACT_START,
    ACT_ADDR,
    ACT_WRITE,
    ACT_READ,
    ACT_STOP
  } action_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_PTR,
    ERR_TIME
  } err_e;

  typedef struct packed {
    logic                       upd;
    err_e                       err;
    logic [TIME_BYTES-1:0][7:0] bytes;
  } time_adv_t;

  function automatic logic [7:0] bcd_inc(input logic [7:0] v);
    logic [7:0] r;
    if (v[3:0] == 4'd9) begin
      r = {v[7:4] + 4'd1, 4'd0};
    end else begin
      r = {v[7:4], v[3:0] + 4'd1};
    end
    return r;
  endfunction

  function automatic logic bcd_ok(input logic [7:0] v, input logic [7:0] lo,
                                  input logic [7:0] hi);
    return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9) && (v >= lo) && (v <= hi);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bcd_rtc_i2c_register_file_unit.sv -----
// top level of the bus-addressed bcd real-time clock with register store
//
//  channel  | direction | handshake               | payload
//  s_axis   | in        | tvalid/tready           | tuser action, tdata addr/dir/byte
//  m_axis   | out       | tvalid/tready           | tdata ack/read byte/error
//  cfg      | in        | cfg_we_i, no wait       | cfg_idx_i, cfg_data_i
//
// one request per cycle; each request is done in the cycle it is accepted and
// its result sits in the output register the next cycle
// store bytes 8 and up live in a ram whose read port follows the pointer
// reset restores the time bytes, control byte and pointer state at once
// s_axis_tready drops only while a result waits and m_axis_tready is low
`default_nettype none

module bcd_rtc_i2c_register_file_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // bus_address[6:0], is_write[7], data_byte[15:8]
  input  wire logic [15:0]                       s_axis_tdata,
  // action[2:0]
  input  wire logic [2:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // acknowledged[0], read_byte[8:1], error_code[10:9], zero[15:11]
  output logic [15:0]                            m_axis_tdata,
  input  wire logic                              cfg_we_i,
  input  wire logic [brtc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [brtc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import brtc_pkg::*;

  logic [FIX_BYTES-1:0][7:0]  store_q, store_d;
  logic [TIME_BYTES-1:0][7:0] snap_q, snap_d;
  logic [STORE_BYTES-1:0]     vld_q, vld_d;
  logic [PTR_W-1:0]           ptr_q, ptr_d, ptr_inc;
  logic                       listen_q, listen_d;
  logic                       expect_q, expect_d;
  logic [15:0]                div_q, div_d;
  logic [6:0]                 dev_q;
  logic [15:0]                tps_q;
  logic                       m_valid_q, m_valid_d;
  logic [15:0]                m_data_q, m_data_d;

  action_e                    act;
  logic                       s_acc;
  logic [6:0]                 bus_addr;
  logic                       is_wr;
  logic [7:0]                 data;
  logic                       ack;
  logic [7:0]                 rd;
  err_e                       err;
  logic [16:0]                div_sum;
  logic [15:0]                limit;
  logic [WIDE_W-1:0]          ptr_x, data_x;
  logic                       ram_we;
  logic [7:0]                 ram_rdata;
  time_adv_t                  adv;

  brtc_time_adv u_adv (
    .time_i (store_q[TIME_BYTES-1:0]),
    .adv_o  (adv)
  );

  brtc_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (data),
    .raddr_i (ptr_d),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign act      = action_e'(s_axis_tuser);
  assign bus_addr = s_axis_tdata[6:0];
  assign is_wr    = s_axis_tdata[7];
  assign data     = s_axis_tdata[15:8];
  assign ptr_x    = WIDE_W'(ptr_q);
  assign data_x   = WIDE_W'(data);
  assign ptr_inc  = (ptr_q == PTR_W'(STORE_BYTES - 1)) ? '0 : ptr_q + PTR_W'(1);

  always_comb begin
    store_d  = store_q;
    snap_d   = snap_q;
    vld_d    = vld_q;
    ptr_d    = ptr_q;
    listen_d = listen_q;
    expect_d = expect_q;
    div_d    = div_q;
    ram_we   = 1'b0;
    ack      = 1'b0;
    rd       = 8'h00;
    err      = ERR_NONE;
    limit    = (tps_q == 16'd0) ? 16'd1 : tps_q;
    div_sum  = {1'b0, div_q} + 17'd1;

    if (s_acc) begin
      case (act)
        ACT_TICK: begin
          if (div_sum >= {1'b0, limit}) begin
            div_d = '0;
            err   = adv.err;
            if (adv.upd) begin
              store_d[TIME_BYTES-1:0] = adv.bytes;
            end
          end else begin
            div_d = div_sum[15:0];
          end
        end
        ACT_START, ACT_STOP: begin
          listen_d = 1'b0;
        end
        ACT_ADDR: begin
          if (bus_addr == dev_q) begin
            listen_d = 1'b1;
            expect_d = is_wr;
            if (!is_wr) begin
              snap_d = store_q[TIME_BYTES-1:0];
            end
            ack = 1'b1;
          end
        end
        ACT_WRITE: begin
          if (listen_q) begin
            if (expect_q) begin
              if (data_x >= WIDE_W'(STORE_BYTES)) begin
                err = ERR_PTR;
              end else begin
                ptr_d    = data[PTR_W-1:0];
                expect_d = 1'b0;
                ack      = 1'b1;
              end
            end else begin
              if (ptr_q == '0) begin
                div_d = '0;
              end
              if (ptr_x < WIDE_W'(FIX_BYTES)) begin
                store_d[ptr_q[2:0]] = data;
              end else begin
                ram_we       = 1'b1;
                vld_d[ptr_q] = 1'b1;
              end
              ptr_d = ptr_inc;
              ack   = 1'b1;
            end
          end
        end
        ACT_READ: begin
          if (listen_q) begin
            if (ptr_x < WIDE_W'(TIME_BYTES)) begin
              rd = snap_q[ptr_q[2:0]];
            end else if (ptr_x < WIDE_W'(FIX_BYTES)) begin
              rd = store_q[ptr_q[2:0]];
            end else begin
              rd = vld_q[ptr_q] ? ram_rdata : 8'h00;
            end
            ptr_d = ptr_inc;
            ack   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    m_data_d = m_data_q;
    if (s_acc) begin
      m_valid_d = 1'b1;
      m_data_d  = {5'b0, err, rd, ack};
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q   <= {8'h03, 8'h00, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h80};
      snap_q    <= '0;
      vld_q     <= '0;
      ptr_q     <= '0;
      listen_q  <= 1'b0;
      expect_q  <= 1'b0;
      div_q     <= '0;
      dev_q     <= DEV_ADDR_RESET;
      tps_q     <= TPS_RESET;
      m_valid_q <= 1'b0;
    end else begin
      store_q   <= store_d;
      snap_q    <= snap_d;
      vld_q     <= vld_d;
      ptr_q     <= ptr_d;
      listen_q  <= listen_d;
      expect_q  <= expect_d;
      div_q     <= div_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEV_ADDR: dev_q <= cfg_data_i[6:0];
          CFG_TPS:      tps_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/brtc_ram.sv -----
// generic single-write, registered-read ram
`default_nettype none

module brtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/brtc_time_adv.sv -----
// one-second bcd advance of the time and date bytes
`default_nettype none

module brtc_time_adv (
  input  wire logic [brtc_pkg::TIME_BYTES-1:0][7:0] time_i,
  output brtc_pkg::time_adv_t                       adv_o
);

  import brtc_pkg::*;

  logic [7:0] sec, min, h12, h24, dow, date, mon, yr, md;
  logic       halt, twelve, pm, pm_n, ok, leap;
  logic       c_min, c_hr, c_day, c_mon, c_yr;
  logic [7:0] sec_n, min_n, hr_n, dow_n, date_n, mon_n, yr_n;
  logic [1:0] leap_sum;

  always_comb begin
    halt   = time_i[0][7];
    sec    = time_i[0] & 8'h7f;
    min    = time_i[1];
    twelve = time_i[2][6];
    pm     = time_i[2][5];
    h12    = time_i[2] & 8'h9f;
    h24    = time_i[2] & 8'hbf;
    dow    = time_i[3];
    date   = time_i[4];
    mon    = time_i[5];
    yr     = time_i[6];

    ok = bcd_ok(sec, 8'h00, 8'h59) && bcd_ok(min, 8'h00, 8'h59) &&
         (twelve ? bcd_ok(h12, 8'h01, 8'h12) : bcd_ok(h24, 8'h00, 8'h23)) &&
         bcd_ok(dow, 8'h01, 8'h07) && bcd_ok(date, 8'h01, 8'h31) &&
         bcd_ok(mon, 8'h01, 8'h12) && bcd_ok(yr, 8'h00, 8'h99);

    // year mod 4 from bcd digits
    leap_sum = yr[1:0] + {yr[4], 1'b0};
    leap     = (leap_sum == 2'd0);
    if (mon == 8'h02) begin
      md = leap ? 8'h29 : 8'h28;
    end else if (mon == 8'h04 || mon == 8'h06 || mon == 8'h09 || mon == 8'h11) begin
      md = 8'h30;
    end else begin
      md = 8'h31;
    end

    c_min = (sec == 8'h59);
    sec_n = c_min ? 8'h00 : bcd_inc(sec);
    c_hr  = c_min && (min == 8'h59);
    min_n = c_hr ? 8'h00 : (c_min ? bcd_inc(min) : min);

    pm_n = pm;
    if (twelve) begin
      c_day = c_hr && pm && (h12 == 8'h11);
      hr_n  = h12;
      if (c_hr) begin
        hr_n = (h12 == 8'h12) ? 8'h01 : bcd_inc(h12);
        if (h12 == 8'h11) begin
          pm_n = ~pm;
        end
      end
    end else begin
      c_day = c_hr && (h24 == 8'h23);
      hr_n  = c_hr ? ((h24 == 8'h23) ? 8'h00 : bcd_inc(h24)) : h24;
    end

    dow_n  = c_day ? ((dow == 8'h07) ? 8'h01 : dow + 8'h01) : dow;
    c_mon  = c_day && (date >= md);
    date_n = c_day ? (c_mon ? 8'h01 : bcd_inc(date)) : date;
    c_yr   = c_mon && (mon == 8'h12);
    mon_n  = c_mon ? (c_yr ? 8'h01 : bcd_inc(mon)) : mon;
    yr_n   = c_yr ? ((yr == 8'h99) ? 8'h00 : bcd_inc(yr)) : yr;

    adv_o.bytes[0] = {1'b0, sec_n[6:0]};
    adv_o.bytes[1] = min_n;
    adv_o.bytes[2] = twelve ? {2'b01, pm_n, hr_n[4:0]} : {2'b00, hr_n[5:0]};
    adv_o.bytes[3] = dow_n;
    adv_o.bytes[4] = date_n;
    adv_o.bytes[5] = mon_n;
    adv_o.bytes[6] = yr_n;

    if (halt) begin
      adv_o.upd = 1'b0;
      adv_o.err = ERR_NONE;
    end else if (!ok) begin
      adv_o.upd = 1'b0;
      adv_o.err = ERR_TIME;
    end else begin
      adv_o.upd = 1'b1;
      adv_o.err = ERR_NONE;
    end
  end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking bench for the bus rtc register file: bus and tick requests against a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import brtc_pkg::*;

  typedef struct packed {
    logic       ack;
    logic [7:0] rd;
    err_e       err;
  } rtc_resp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // bus_address[6:0], is_write[7], data_byte[15:8]
  logic [15:0]           s_axis_tdata = '0;
  // action[2:0]
  logic [2:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // acknowledged[0], read_byte[8:1], error_code[10:9], zero[15:11]
  logic [15:0]           m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  bcd_rtc_i2c_register_file_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predicted device state
  logic [7:0]  regs_m [STORE_BYTES];
  logic [7:0]  snap_m [TIME_BYTES];
  int unsigned ptr_m;
  int unsigned div_m;
  bit          listen_m;
  bit          want_ptr_m;
  logic [6:0]  dev_addr_m;
  logic [15:0] tps_m;

  rtc_resp_t   resp_q [$];
  int unsigned errors_seen;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned rx_left;
  bit          gaps_on;
  bit          stalls_on;

  always #5 clk_i = ~clk_i;

  function automatic void clear_rtc_state();
    foreach (regs_m[i]) regs_m[i] = 8'h00;
    foreach (snap_m[i]) snap_m[i] = 8'h00;
    regs_m[0]  = 8'h80;
    regs_m[3]  = 8'h01;
    regs_m[4]  = 8'h01;
    regs_m[5]  = 8'h01;
    regs_m[7]  = 8'h03;
    ptr_m      = 0;
    div_m      = 0;
    listen_m   = 1'b0;
    want_ptr_m = 1'b0;
    dev_addr_m = DEV_ADDR_RESET;
    tps_m      = TPS_RESET;
  endfunction

  function automatic bit bcd_val(input logic [7:0] v, input int unsigned lo,
                                 input int unsigned hi, output int unsigned n);
    n = 32'(v[7:4]) * 10 + 32'(v[3:0]);
    return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9) && (n >= lo) && (n <= hi);
  endfunction

  function automatic logic [7:0] to_bcd(input int unsigned d);
    return {4'(d / 10), 4'(d % 10)};
  endfunction

  function automatic int unsigned month_len(input int unsigned mon, input int unsigned yr);
    int unsigned days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (mon == 2 && yr % 4 == 0) return 29;
    return days[(mon - 1) % 12];
  endfunction

  function automatic err_e advance_clock();
    int unsigned sec, mins, hr, dow, day, mon, yr, h12;
    bit ok, twelve;
    twelve = regs_m[2][6];
    if (regs_m[0][7]) return ERR_NONE;
    ok = bcd_val(regs_m[0] & 8'h7f, 0, 59, sec);
    ok &= bcd_val(regs_m[1], 0, 59, mins);
    if (twelve) begin
      ok &= bcd_val(regs_m[2] & 8'h9f, 1, 12, hr);
      if (ok) begin
        if (hr == 12) hr = 0;
        if (regs_m[2][5]) hr += 12;
      end
    end else begin
      ok &= bcd_val(regs_m[2] & 8'hbf, 0, 23, hr);
    end
    ok &= bcd_val(regs_m[3], 1, 7, dow);
    ok &= bcd_val(regs_m[4], 1, 31, day);
    ok &= bcd_val(regs_m[5], 1, 12, mon);
    ok &= bcd_val(regs_m[6], 0, 99, yr);
    if (!ok) return ERR_TIME;

    sec++;
    if (sec == 60) begin
      sec = 0;
      mins++;
      if (mins == 60) begin
        mins = 0;
        hr++;
        if (hr == 24) begin
          hr  = 0;
          dow = dow % 7 + 1;
          day++;
          if (day > month_len(mon, yr)) begin
            day = 1;
            mon++;
            if (mon > 12) begin
              mon = 1;
              yr  = (yr + 1) % 100;
            end
          end
        end
      end
    end

    regs_m[0] = (regs_m[0] & 8'h80) | (to_bcd(sec) & 8'h7f);
    regs_m[1] = to_bcd(mins);
    if (twelve) begin
      h12 = (hr % 12 != 0) ? hr % 12 : 12;
      regs_m[2] = (regs_m[2] & ~8'h9f) | (to_bcd(h12) & 8'h9f);
      regs_m[2][5] = (hr >= 12);
    end else begin
      regs_m[2] = (regs_m[2] & ~8'hbf) | (to_bcd(hr) & 8'hbf);
    end
    regs_m[3] = 8'(dow);
    regs_m[4] = to_bcd(day);
    regs_m[5] = to_bcd(mon);
    regs_m[6] = to_bcd(yr);
    return ERR_NONE;
  endfunction

  function automatic rtc_resp_t predict_resp(input action_e act, input logic [6:0] addr,
                                             input logic wr, input logic [7:0] data);
    rtc_resp_t   r;
    int unsigned lim;
    r = '{ack: 1'b0, rd: 8'h00, err: ERR_NONE};
    case (act)
      ACT_TICK: begin
        lim = (tps_m == 0) ? 1 : tps_m;
        div_m++;
        if (div_m >= lim) begin
          div_m = 0;
          r.err = advance_clock();
        end
      end
      ACT_START, ACT_STOP: begin
        listen_m = 1'b0;
      end
      ACT_ADDR: begin
        if (addr == dev_addr_m) begin
          listen_m   = 1'b1;
          want_ptr_m = wr;
          if (!wr) foreach (snap_m[i]) snap_m[i] = regs_m[i];
          r.ack = 1'b1;
        end
      end
      ACT_WRITE: begin
        if (listen_m) begin
          if (want_ptr_m) begin
            if (data >= STORE_BYTES) begin
              r.err = ERR_PTR;
            end else begin
              ptr_m      = data;
              want_ptr_m = 1'b0;
              r.ack      = 1'b1;
            end
          end else begin
            if (ptr_m == 0) div_m = 0;
            regs_m[ptr_m] = data;
            ptr_m = (ptr_m + 1) % STORE_BYTES;
            r.ack = 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (listen_m) begin
          r.rd  = (ptr_m < TIME_BYTES) ? snap_m[ptr_m] : regs_m[ptr_m];
          ptr_m = (ptr_m + 1) % STORE_BYTES;
          r.ack = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
    errors_seen++;
    if (errors_seen <= 100) $error("%s mismatch: expected %0h, got %0h", field, want, got);
  endtask

  always @(posedge clk_i) begin : check_resp
    rtc_resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (resp_q.size() == 0) begin
        errors_seen++;
        $error("response with no request waiting: %h", m_axis_tdata);
      end else begin
        want = resp_q.pop_front();
        if (m_axis_tdata[0] !== want.ack)
          report_mismatch("acknowledged", 8'(want.ack), 8'(m_axis_tdata[0]));
        if (m_axis_tdata[8:1] !== want.rd)
          report_mismatch("read_byte", want.rd, m_axis_tdata[8:1]);
        if (m_axis_tdata[10:9] !== want.err)
          report_mismatch("error_code", 8'(want.err), 8'(m_axis_tdata[10:9]));
      end
    end
  end

  always @(posedge clk_i) begin : drive_ready
    bit stall;
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else begin
      stall = stalls_on && ($urandom_range(0, 2) == 0);
      m_axis_tready <= !stall;
      rx_left <= stall ? $urandom_range(0, 12) : $urandom_range(0, 10);
    end
  end

  task automatic send_req(input action_e act, input logic [6:0] addr, input logic wr,
                          input logic [7:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {data, wr, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    resp_q.push_back(predict_resp(act, addr, wr, data));
    items_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 15);
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic put_ctl(input action_e act);
    send_req(act, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
             8'($urandom_range(0, 255)));
  endtask

  task automatic put_addr(input logic [6:0] addr, input logic wr);
    send_req(ACT_ADDR, addr, wr, 8'($urandom_range(0, 255)));
  endtask

  task automatic put_byte(input logic [7:0] data);
    send_req(ACT_WRITE, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), data);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DEV_ADDR) dev_addr_m = val[6:0];
    else tps_m = val;
  endtask

  function automatic logic [6:0] pick_addr();
    return ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : dev_addr_m;
  endfunction

  // mismatch, idle bus, pointer range and wrap, midnight rollover
  task automatic test_bus_protocol();
    put_addr(7'd105, 1'b1);
    put_byte(8'h12);
    put_ctl(ACT_READ);
    put_addr(DEV_ADDR_RESET, 1'b0);
    put_ctl(ACT_READ);
    put_ctl(ACT_READ);
    put_ctl(ACT_START);
    put_addr(DEV_ADDR_RESET, 1'b1);
    put_byte(8'd64);
    put_byte(8'hff);
    put_byte(8'd63);
    put_byte(8'hff);
    put_byte(8'h59);
    put_byte(8'h59);
    put_byte(8'h23);
    put_ctl(ACT_TICK);
    put_ctl(ACT_STOP);
    put_addr(DEV_ADDR_RESET, 1'b0);
    repeat (5) put_ctl(ACT_READ);
    put_ctl(ACT_STOP);
  endtask

  // bad bcd, halt bit, date past month end, divider extremes
  task automatic test_clock_halt_and_errors();
    put_addr(DEV_ADDR_RESET, 1'b1);
    put_byte(8'h00);
    put_byte(8'h5a);
    put_ctl(ACT_TICK);
    put_addr(DEV_ADDR_RESET, 1'b1);
    put_byte(8'h00);
    put_byte(8'h80);
    put_ctl(ACT_TICK);
    put_addr(DEV_ADDR_RESET, 1'b1);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h12);
    put_byte(8'h03);
    put_byte(8'h31);
    put_byte(8'h04);
    put_ctl(ACT_TICK);
    write_reg(CFG_TPS, 16'd0);
    repeat (2) put_ctl(ACT_TICK);
    write_reg(CFG_TPS, 16'hffff);
    repeat (3) put_ctl(ACT_TICK);
  endtask

  task automatic load_time();
    logic [7:0]  t [TIME_BYTES];
    int unsigned mon, yr, hr, span;
    bit          twelve;
    twelve = 1'($urandom_range(0, 1));
    mon = ($urandom_range(0, 2) == 0) ? 2 : $urandom_range(1, 12);
    yr = ($urandom_range(0, 3) == 0) ? 4 * $urandom_range(0, 24) : $urandom_range(0, 99);
    t[0] = to_bcd(($urandom_range(0, 1) == 0) ? 59 : $urandom_range(0, 59));
    if ($urandom_range(0, 9) == 0) t[0][7] = 1'b1;
    t[1] = to_bcd(($urandom_range(0, 1) == 0) ? 59 : $urandom_range(0, 59));
    if (twelve) begin
      hr = ($urandom_range(0, 1) == 0) ? 11 + $urandom_range(0, 1) : $urandom_range(1, 12);
      t[2] = 8'h40 | to_bcd(hr);
      t[2][5] = 1'($urandom_range(0, 1));
    end else begin
      t[2] = to_bcd(($urandom_range(0, 1) == 0) ? 23 : $urandom_range(0, 23));
    end
    t[3] = to_bcd($urandom_range(1, 7));
    t[4] = to_bcd(($urandom_range(0, 1) == 0) ? month_len(mon, yr) - $urandom_range(0, 1)
                                              : $urandom_range(1, 31));
    t[5] = to_bcd(mon);
    t[6] = to_bcd(yr);
    if ($urandom_range(0, 9) == 0) t[$urandom_range(0, 6)] = 8'($urandom_range(0, 255));
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, TIME_BYTES) : TIME_BYTES;
    put_ctl(ACT_START);
    put_addr(pick_addr(), 1'b1);
    put_byte(8'h00);
    for (int i = 0; i < span; i++) put_byte(t[i]);
    put_ctl(ACT_STOP);
    repeat ($urandom_range(1, 4)) put_ctl(ACT_TICK);
  endtask

  task automatic read_run();
    put_ctl(ACT_START);
    put_addr(pick_addr(), 1'b1);
    if ($urandom_range(0, 9) == 0) put_byte(8'($urandom_range(STORE_BYTES, 255)));
    put_byte(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 7))
                                         : 8'($urandom_range(0, STORE_BYTES - 1)));
    if ($urandom_range(0, 1) == 0) put_ctl(ACT_START);
    put_addr(pick_addr(), 1'b0);
    if ($urandom_range(0, 3) == 0) put_ctl(ACT_TICK);
    repeat ($urandom_range(1, 10)) put_ctl(ACT_READ);
    put_ctl(ACT_STOP);
  endtask

  task automatic store_run();
    put_ctl(ACT_START);
    put_addr(pick_addr(), 1'b1);
    put_byte(8'($urandom_range(TIME_BYTES, STORE_BYTES - 1)));
    repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
    put_ctl(ACT_STOP);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned first, pick;
    first = items_sent;
    while (items_sent - first < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        load_time();
      end else if (pick < 55) begin
        read_run();
      end else if (pick < 70) begin
        store_run();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) put_ctl(ACT_TICK);
      end else begin
        // includes the unused action codes
        repeat ($urandom_range(1, 4))
          send_req(action_e'(3'($urandom_range(0, 7))), pick_addr(),
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_random_traffic();
    write_reg(CFG_DEV_ADDR, 16'd0);
    write_reg(CFG_TPS, 16'd1);
    run_random(350);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_reg(CFG_DEV_ADDR, 16'd127);
    write_reg(CFG_TPS, 16'd2);
    run_random(250);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_reg(CFG_DEV_ADDR, 16'($urandom_range(0, 127)));
    write_reg(CFG_TPS, 16'd3);
    run_random(300);
    stalls_on = 1'b0;
    write_reg(CFG_DEV_ADDR, 16'(DEV_ADDR_RESET));
    write_reg(CFG_TPS, 16'hffff);
    run_random(100);
  endtask

  initial begin
    clear_rtc_state();
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    burst_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_bus_protocol();
    test_clock_halt_and_errors();
    test_random_traffic();
    wait_idle();
    if (errors_seen == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
